// ===== hdl/qpe_pkg.sv =====
`default_nettype none

package qpe_pkg;

  localparam logic [7:0] CharTab   = 8'd9;
  localparam logic [7:0] CharLf    = 8'd10;
  localparam logic [7:0] CharCr    = 8'd13;
  localparam logic [7:0] CharSpace = 8'd32;
  localparam logic [7:0] CharEq    = 8'd61;
  localparam logic [7:0] PlainLo1  = 8'd33;
  localparam logic [7:0] PlainHi1  = 8'd60;
  localparam logic [7:0] PlainLo2  = 8'd62;
  localparam logic [7:0] PlainHi2  = 8'd126;
  localparam logic [7:0] LimitRst  = 8'd73;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       msg_last;
  } qpe_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       msg_end;
  } qpe_out_t;

  // one accepted byte after classification: optional held space/tab, optional own unit
  typedef struct packed {
    logic       held_v;
    logic       held_tab;
    logic       held_esc;
    logic       cur_v;
    logic [7:0] cur_byte;
    logic       cur_esc;
    logic       msg_last;
  } qpe_entry_t;

  typedef enum logic [2:0] {
    ST_UNIT,
    ST_BRK_CR,
    ST_BRK_LF,
    ST_BODY,
    ST_HEX_HI,
    ST_HEX_LO
  } qpe_state_e;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] w;
    w = {4'd0, v};
    if (v < 4'd10) begin
      hex_digit = 8'd48 + w;
    end else begin
      hex_digit = 8'd55 + w;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/quoted_printable_encoder_top.sv =====
`default_nettype none

// channel | signals                        | direction
// input   | in_valid_i, in_stall_o, in_data_i    | byte request in
// output  | out_valid_o, out_stall_i, out_data_o | one encoded character out
// config  | cfg_valid_i, cfg_ready_o, cfg_data_i | line limit write
//
// the back end emits one character per cycle unless stalled: a literal byte is
// one character, an escape three, a soft line break three more; a held space/tab
// gives none until its successor arrives, so the rate is bound by the output channel
// a two-entry queue lets the front take a new request while the back works
// reset clears the queue, held byte, line count and sets the limit to 73

module quoted_printable_encoder_top import qpe_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire qpe_in_t    in_data_i,
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  output      qpe_out_t   out_data_o,
  input  wire logic       cfg_valid_i,
  output      logic       cfg_ready_o,
  input  wire logic [7:0] cfg_data_i
);

  logic [7:0] line_limit_q;
  logic       q_full, q_push, q_pop, q_valid;
  qpe_entry_t push_entry, pop_entry;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_limit_q <= LimitRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      line_limit_q <= cfg_data_i;
    end
  end

  qpe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (push_entry)
  );

  qpe_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (pop_entry)
  );

  qpe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .line_limit_i (line_limit_q),
    .q_valid_i    (q_valid),
    .q_entry_i    (pop_entry),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

// ===== hdl/qpe_front.sv =====
`default_nettype none

module qpe_front import qpe_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire qpe_in_t    in_data_i,
  output      logic       in_stall_o,
  input  wire logic       q_full_i,
  output      logic       q_push_o,
  output      qpe_entry_t q_entry_o
);

  logic held_v_q, held_v_d;
  logic held_tab_q, held_tab_d;
  logic accept;
  logic is_ws, is_crlf, is_plain, hold_now;
  logic [7:0] b;

  assign b          = in_data_i.data_byte;
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign is_ws    = (b == CharSpace) || (b == CharTab);
  assign is_crlf  = (b == CharCr) || (b == CharLf);
  assign is_plain = ((b >= PlainLo1) && (b <= PlainHi1)) ||
                    ((b >= PlainLo2) && (b <= PlainHi2));
  assign hold_now = is_ws && !in_data_i.msg_last;

  always_comb begin
    q_entry_o.held_v   = held_v_q;
    q_entry_o.held_tab = held_tab_q;
    q_entry_o.held_esc = is_crlf;
    q_entry_o.cur_v    = !hold_now;
    q_entry_o.cur_byte = b;
    q_entry_o.cur_esc  = !is_plain;
    q_entry_o.msg_last = in_data_i.msg_last;
  end

  assign q_push_o = accept && (held_v_q || !hold_now);

  always_comb begin
    held_v_d   = held_v_q;
    held_tab_d = held_tab_q;
    if (accept) begin
      held_v_d   = hold_now;
      held_tab_d = hold_now && (b == CharTab);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_v_q   <= 1'b0;
      held_tab_q <= 1'b0;
    end else begin
      held_v_q   <= held_v_d;
      held_tab_q <= held_tab_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/qpe_fifo.sv =====
`default_nettype none

module qpe_fifo import qpe_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire qpe_entry_t push_data_i,
  output      logic       full_o,
  input  wire logic       pop_i,
  output      logic       valid_o,
  output      qpe_entry_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  qpe_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/qpe_back.sv =====
`default_nettype none

module qpe_back import qpe_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] line_limit_i,
  input  wire logic       q_valid_i,
  input  wire qpe_entry_t q_entry_i,
  output      logic       q_pop_o,
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  output      qpe_out_t   out_data_o
);

  qpe_state_e state_q, state_d;
  qpe_entry_t ent_q;
  logic       ent_valid_q;
  logic       unit_sel_q;
  logic [8:0] cnt_q, cnt_d;
  qpe_out_t   out_q;
  logic       out_valid_q;

  logic       adv, fire, brk, unit_done, last_unit, ent_done;
  logic [7:0] unit_byte, ch;
  logic       unit_esc;

  assign adv  = !out_valid_q || !out_stall_i;
  assign fire = ent_valid_q && adv;
  assign brk  = cnt_q >= {1'b0, line_limit_i};

  assign unit_byte = unit_sel_q ? ent_q.cur_byte :
                     (ent_q.held_tab ? CharTab : CharSpace);
  assign unit_esc  = unit_sel_q ? ent_q.cur_esc : ent_q.held_esc;
  assign last_unit = unit_sel_q || !ent_q.cur_v;

  // next state
  always_comb begin
    case (state_q)
      ST_UNIT: begin
        if (brk) begin
          state_d = ST_BRK_CR;
        end else if (unit_esc) begin
          state_d = ST_HEX_HI;
        end else begin
          state_d = ST_UNIT;
        end
      end
      ST_BRK_CR: state_d = ST_BRK_LF;
      ST_BRK_LF: state_d = ST_BODY;
      ST_BODY:   state_d = unit_esc ? ST_HEX_HI : ST_UNIT;
      ST_HEX_HI: state_d = ST_HEX_LO;
      ST_HEX_LO: state_d = ST_UNIT;
      default:   state_d = ST_UNIT;
    endcase
  end

  // character and line count
  always_comb begin
    ch        = CharEq;
    unit_done = 1'b0;
    cnt_d     = cnt_q;
    case (state_q)
      ST_UNIT: begin
        if (brk) begin
          cnt_d = '0;
        end else if (!unit_esc) begin
          ch        = unit_byte;
          cnt_d     = cnt_q + 9'd1;
          unit_done = 1'b1;
        end
      end
      ST_BRK_CR: ch = CharCr;
      ST_BRK_LF: ch = CharLf;
      ST_BODY: begin
        if (!unit_esc) begin
          ch        = unit_byte;
          cnt_d     = cnt_q + 9'd1;
          unit_done = 1'b1;
        end
      end
      ST_HEX_HI: ch = hex_digit(unit_byte[7:4]);
      ST_HEX_LO: begin
        ch        = hex_digit(unit_byte[3:0]);
        cnt_d     = cnt_q + 9'd3;
        unit_done = 1'b1;
      end
      default: ch = CharEq;
    endcase
    if (unit_done && last_unit && ent_q.msg_last) begin
      cnt_d = '0;
    end
  end

  assign ent_done = fire && unit_done && last_unit;
  assign q_pop_o  = q_valid_i && (!ent_valid_q || ent_done);

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ent_q <= q_entry_i;
    end
    if (adv) begin
      out_q.out_char <= ch;
      out_q.run_last <= unit_done && last_unit;
      out_q.msg_end  <= unit_done && last_unit && ent_q.msg_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_UNIT;
      ent_valid_q <= 1'b0;
      unit_sel_q  <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= ent_valid_q;
      end
      if (fire) begin
        state_q <= state_d;
        cnt_q   <= cnt_d;
      end
      if (q_pop_o) begin
        ent_valid_q <= 1'b1;
        unit_sel_q  <= !q_entry_i.held_v;
      end else if (ent_done) begin
        ent_valid_q <= 1'b0;
      end else if (fire && unit_done) begin
        unit_sel_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qpe_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int LongHold   = 400;
  localparam int DrainWait  = 20;
  localparam int TailCycles = 40;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    int          n_typed;
    logic [23:0] typed;
  } dir_row_t;

  logic       clk;
  logic       rst_ni;
  logic       in_valid;
  logic       in_stall;
  qpe_in_t    in_data;
  logic       out_valid;
  logic       out_stall;
  qpe_out_t   out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  logic [7:0] lim_reg;
  logic [8:0] line_cnt;
  logic       held_v;
  logic       held_tab;

  qpe_out_t   unit_chars[$];
  qpe_out_t   expected_chars[$];
  int         fail_cnt;
  int         cycle_cnt;
  int         snd_calm;
  logic       hold_off_req;

  // typed rows start a fresh message at the reset limit
  dir_row_t dir_rows [0:24] = '{
    '{8'h41,     1'b1, 1, "A"},
    '{8'h00,     1'b1, 3, "=00"},
    '{8'hFF,     1'b1, 3, "=FF"},
    '{CharEq,    1'b1, 3, "=3D"},
    '{PlainLo1,  1'b1, 1, "!"},
    '{PlainHi2,  1'b1, 1, "~"},
    '{PlainHi1,  1'b1, 1, "<"},
    '{PlainLo2,  1'b1, 1, ">"},
    '{CharSpace, 1'b1, 3, "=20"},
    '{CharTab,   1'b1, 3, "=09"},
    '{CharCr,    1'b1, 3, "=0D"},
    '{CharLf,    1'b1, 3, "=0A"},
    '{8'h7F,     1'b1, 3, "=7F"},
    '{8'h80,     1'b1, 3, "=80"},
    '{CharSpace, 1'b0, 0, '0},
    '{8'h78,     1'b0, 0, '0},
    '{CharTab,   1'b0, 0, '0},
    '{CharCr,    1'b0, 0, '0},
    '{CharSpace, 1'b0, 0, '0},
    '{CharSpace, 1'b0, 0, '0},
    '{CharLf,    1'b0, 0, '0},
    '{CharTab,   1'b0, 0, '0},
    '{8'hC3,     1'b0, 0, '0},
    '{CharSpace, 1'b0, 0, '0},
    '{8'h7A,     1'b1, 0, '0}
  };

  quoted_printable_encoder_top DUT (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] hex_ch(input logic [3:0] v);
    logic [7:0] w;
    w = {4'd0, v};
    return (v < 4'd10) ? 8'd48 + w : 8'd55 + w;
  endfunction

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(33, 60));
      1: return 8'($urandom_range(62, 126));
      2: return CharSpace;
      3: return CharTab;
      4: return CharCr;
      5: return CharLf;
      6: return CharEq;
      7: return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_char(input logic [7:0] c);
    qpe_out_t r;
    r = '0;
    r.out_char = c;
    unit_chars.push_back(r);
  endtask

  task automatic emit_unit(input logic [7:0] b, input logic esc);
    // a limit of zero puts a soft break before every unit
    if (line_cnt >= {1'b0, lim_reg}) begin
      push_char(CharEq);
      push_char(CharCr);
      push_char(CharLf);
      line_cnt = '0;
    end
    if (esc) begin
      push_char(CharEq);
      push_char(hex_ch(b[7:4]));
      push_char(hex_ch(b[3:0]));
      line_cnt = line_cnt + 9'd3;
    end else begin
      push_char(b);
      line_cnt = line_cnt + 9'd1;
    end
  endtask

  task automatic qp_encode(input qpe_in_t req);
    logic       plain;
    logic [7:0] b;
    qpe_out_t   tail;
    b = req.data_byte;
    unit_chars.delete();
    // held space or tab is escaped only when a line end follows
    if (held_v) begin
      emit_unit(held_tab ? CharTab : CharSpace, (b == CharCr) || (b == CharLf));
      held_v = 1'b0;
    end
    plain = ((b >= PlainLo1) && (b <= PlainHi1)) || ((b >= PlainLo2) && (b <= PlainHi2));
    if (plain) begin
      emit_unit(b, 1'b0);
    end else if ((b == CharSpace) || (b == CharTab)) begin
      if (req.msg_last) begin
        emit_unit(b, 1'b1);
      end else begin
        held_v   = 1'b1;
        held_tab = (b == CharTab);
      end
    end else begin
      emit_unit(b, 1'b1);
    end
    if (unit_chars.size() > 0) begin
      tail          = unit_chars.pop_back();
      tail.run_last = 1'b1;
      tail.msg_end  = req.msg_last;
      unit_chars.push_back(tail);
    end
    if (req.msg_last) begin
      line_cnt = '0;
      held_v   = 1'b0;
      held_tab = 1'b0;
    end
  endtask

  task automatic send_byte(input qpe_in_t req, input int n_typed, input logic [23:0] typed);
    int       gap;
    qpe_out_t r;
    gap = draw_wait(snd_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    qp_encode(req);
    if (n_typed == 0) begin
      foreach (unit_chars[i]) expected_chars.push_back(unit_chars[i]);
    end else begin
      for (int i = 0; i < n_typed; i++) begin
        r          = '0;
        r.out_char = typed[8*(n_typed-1-i) +: 8];
        r.run_last = (i == n_typed - 1);
        r.msg_end  = r.run_last && req.msg_last;
        expected_chars.push_back(r);
      end
    end
  endtask

  task automatic send_message(input int len, input logic noisy);
    qpe_in_t req;
    for (int i = 0; i < len; i++) begin
      req.data_byte = pick_byte();
      req.msg_last  = (i == len - 1) || (noisy && ($urandom_range(0, 15) == 0));
      send_byte(req, 0, '0);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    drain_results();
    repeat (DrainWait) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    lim_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    qpe_in_t    req;
    logic [7:0] lims [6];
    int         sent;
    int         len;
    logic       paused;
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    lim_reg      = LimitRst;
    line_cnt     = '0;
    held_v       = 1'b0;
    held_tab     = 1'b0;
    snd_calm     = 0;
    hold_off_req = 1'b0;
    paused       = 1'b0;
    lims = '{8'd1, 8'd255, 8'd0, 8'd2, 8'($urandom_range(3, 254)), LimitRst};
    repeat (11) @(negedge clk);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      req.data_byte = dir_rows[i].data;
      req.msg_last  = dir_rows[i].last;
      send_byte(req, dir_rows[i].n_typed, dir_rows[i].typed);
    end

    for (int p = 0; p < 6; p++) begin
      write_limit(lims[p]);
      if (p == 0) hold_off_req = 1'b1;
      if (p == 1) begin
        // one long message so the line count can reach the top limit
        send_message(120, 1'b0);
      end else begin
        sent = 0;
        while (sent < 20) begin
          len = $urandom_range(1, 12);
          send_message(len, 1'b1);
          sent += len;
          if ((p == 3) && !paused && (sent >= 15)) begin
            drain_results();
            paused = 1'b1;
          end
        end
      end
    end

    drain_results();
    repeat (TailCycles) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    int       k;
    int       calm;
    qpe_out_t want;
    calm      = 0;
    fail_cnt  = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (LongHold) @(negedge clk);
        hold_off_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        k = draw_wait(calm);
        if (k > 0) begin
          out_stall <= 1'b1;
          repeat (k) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
      do @(posedge clk); while (!out_valid);
      if (expected_chars.size() == 0) begin
        $error("out_char expected none actual %h", out_data.out_char);
        fail_cnt++;
      end else begin
        want = expected_chars.pop_front();
        if (out_data.out_char !== want.out_char) begin
          $error("out_char expected %h actual %h", want.out_char, out_data.out_char);
          fail_cnt++;
        end
        if (out_data.run_last !== want.run_last) begin
          $error("run_last expected %b actual %b", want.run_last, out_data.run_last);
          fail_cnt++;
        end
        if (out_data.msg_end !== want.msg_end) begin
          $error("msg_end expected %b actual %b", want.msg_end, out_data.msg_end);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule
